### hdl/tccw_pkg.sv
// shared types, codes and constants for the text console cursor writer
`timescale 1ns / 1ps

package tccw_pkg;

  // screen geometry defaults
  localparam int unsigned COLUMNS_DEF    = 80;
  localparam int unsigned ROWS_DEF       = 25;
  localparam int unsigned TAB_BLANKS_DEF = 4;

  // field widths
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned ACTION_W = 2;

  // full linear index before the 11-bit mask: row * columns + column, plus one for a delete
  localparam int unsigned LIN_W = ROW_W + COL_W + 1;

  // tab blank counter covers at most four blanks
  localparam int unsigned TAB_CNT_W = 2;

  // command queue depth between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  // navigation directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  // result kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_REPORT = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_e;

  // decoded command kinds
  typedef enum logic [2:0] {
    K_MOVE  = 3'd0,
    K_NL    = 3'd1,
    K_BS    = 3'd2,
    K_TAB   = 3'd3,
    K_DEL   = 3'd4,
    K_PRINT = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic [DIR_W-1:0]  dir;
  } cmd_t;

  typedef struct packed {
    act_e               action;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               last;
  } result_t;

endpackage

### hdl/tccw_front.sv
// front stage: accepts input words and decodes them into commands
`timescale 1ns / 1ps

module tccw_front import tccw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic [DIR_W-1:0]  direction_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  logic valid_q;
  cmd_t cmd_q;
  cmd_t cmd_d;

  // classify the incoming word
  always_comb begin
    cmd_d.ch  = character_i;
    cmd_d.dir = direction_i;
    if (mode_i) begin
      cmd_d.kind = K_MOVE;
    end else begin
      unique case (character_i)
        CH_NL:   cmd_d.kind = K_NL;
        CH_BS:   cmd_d.kind = K_BS;
        CH_TAB:  cmd_d.kind = K_TAB;
        CH_DEL:  cmd_d.kind = K_DEL;
        default: cmd_d.kind = K_PRINT;
      endcase
    end
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // holding register toward the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

### hdl/tccw_fifo.sv
// small command queue between the front and back stages
`timescale 1ns / 1ps

module tccw_fifo import tccw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

### hdl/tccw_back.sv
// back stage: cursor state and result sequencer, one result word per cycle unless the output stalls
`timescale 1ns / 1ps

module tccw_back import tccw_pkg::*; #(
  parameter int unsigned COLUMNS    = COLUMNS_DEF,
  parameter int unsigned ROWS       = ROWS_DEF,
  parameter int unsigned TAB_BLANKS = TAB_BLANKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  cmd_t               cmd_i,
  input  logic [COLOR_W-1:0] color_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o
);

  // sequencer phases
  localparam logic [1:0] PH_BODY   = 2'd0;
  localparam logic [1:0] PH_CLEAR  = 2'd1;
  localparam logic [1:0] PH_REPORT = 2'd2;

  logic                 busy_q;
  cmd_t                 cmd_q;
  logic [1:0]           phase_q, phase_d;
  logic [TAB_CNT_W-1:0] tab_q, tab_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic                 out_valid_q;
  result_t              out_q;
  result_t              res_d;

  logic                 step;
  logic                 done;
  logic                 add_one;
  logic [COL_W:0]       col_inc;
  logic [ROW_W:0]       row_inc;
  logic                 col_wrap;
  logic                 adv_over;
  logic [ROW_W-1:0]     adv_row;
  logic [COL_W-1:0]     adv_col;
  logic [ROW_W-1:0]     a_row;
  logic [COL_W-1:0]     a_col;
  logic [LIN_W-1:0]     lin;

  assign step        = busy_q && (!out_valid_q || res_ready_i);
  assign cmd_ready_o = !busy_q || (step && done);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // one-column advance with wrap and overflow detection
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign col_wrap = col_inc >= (COL_W + 1)'(COLUMNS);
  assign adv_over = col_wrap && (row_inc >= (ROW_W + 1)'(ROWS));
  assign adv_row  = adv_over ? '0 : (col_wrap ? row_inc[ROW_W-1:0] : row_q);
  assign adv_col  = col_wrap ? '0 : col_inc[COL_W-1:0];

  // next cursor and result of this step
  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    phase_d      = phase_q;
    tab_d        = tab_q;
    done         = 1'b0;
    add_one      = 1'b0;
    res_d.action = ACT_REPORT;
    res_d.value  = '0;
    res_d.last   = 1'b0;
    unique case (phase_q)
      PH_BODY: begin
        unique case (cmd_q.kind)
          K_MOVE: begin
            unique case (cmd_q.dir)
              DIR_UP: begin
                if (row_q != '0) row_d = row_q - 1'b1;
              end
              DIR_DOWN: begin
                if (row_inc < (ROW_W + 1)'(ROWS)) row_d = row_inc[ROW_W-1:0];
              end
              DIR_LEFT: begin
                if (col_q != '0) col_d = col_q - 1'b1;
              end
              default: begin
                if (!col_wrap) col_d = col_inc[COL_W-1:0];
              end
            endcase
            res_d.last = 1'b1;
            done       = 1'b1;
          end
          K_NL: begin
            col_d = '0;
            if (row_inc >= (ROW_W + 1)'(ROWS)) begin
              row_d        = '0;
              res_d.action = ACT_CLEAR;
              res_d.value  = {color_i, CH_BLANK};
              phase_d      = PH_REPORT;
            end else begin
              row_d      = row_inc[ROW_W-1:0];
              res_d.last = 1'b1;
              done       = 1'b1;
            end
          end
          K_BS: begin
            if (col_q != '0) begin
              col_d        = col_q - 1'b1;
              res_d.action = ACT_WRITE;
              res_d.value  = {color_i, CH_BLANK};
              phase_d      = PH_REPORT;
            end else begin
              res_d.last = 1'b1;
              done       = 1'b1;
            end
          end
          K_TAB: begin
            row_d        = adv_row;
            col_d        = adv_col;
            res_d.action = ACT_WRITE;
            res_d.value  = {color_i, CH_BLANK};
            if (adv_over) begin
              phase_d = PH_CLEAR;
            end else if (tab_q == TAB_CNT_W'(TAB_BLANKS - 1)) begin
              phase_d = PH_REPORT;
            end else begin
              tab_d = tab_q + 1'b1;
            end
          end
          K_DEL: begin
            if (!col_wrap) begin
              add_one      = 1'b1;
              res_d.action = ACT_WRITE;
              res_d.value  = {color_i, CH_BLANK};
              phase_d      = PH_REPORT;
            end else begin
              res_d.last = 1'b1;
              done       = 1'b1;
            end
          end
          K_PRINT: begin
            row_d        = adv_row;
            col_d        = adv_col;
            res_d.action = ACT_WRITE;
            res_d.value  = {color_i, cmd_q.ch};
            phase_d      = adv_over ? PH_CLEAR : PH_REPORT;
          end
          default: begin
            res_d.last = 1'b1;
            done       = 1'b1;
          end
        endcase
      end
      PH_CLEAR: begin
        res_d.action = ACT_CLEAR;
        res_d.value  = {color_i, CH_BLANK};
        phase_d      = PH_REPORT;
      end
      default: begin
        res_d.last = 1'b1;
        done       = 1'b1;
      end
    endcase

    // cell index: writes use the cursor before the step, reports the one after
    a_row      = (res_d.action == ACT_WRITE) ? row_q : row_d;
    a_col      = (res_d.action == ACT_WRITE) ? col_q : col_d;
    lin        = LIN_W'(a_row) * LIN_W'(COLUMNS) + LIN_W'(a_col) + LIN_W'(add_one);
    res_d.addr = (res_d.action == ACT_CLEAR) ? '0 : lin[ADDR_W-1:0];
    res_d.row  = row_d;
    res_d.col  = col_d;
  end

  // control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_BODY;
      tab_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        row_q       <= row_d;
        col_q       <= col_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // a new command restarts the sequence
      if (cmd_ready_o) begin
        busy_q  <= cmd_valid_i;
        phase_q <= PH_BODY;
        tab_q   <= '0;
      end else if (step) begin
        phase_q <= phase_d;
        tab_q   <= tab_d;
      end
    end
  end

  // command and output word registers
  always_ff @(posedge clk_i) begin
    if (cmd_ready_o && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (step) begin
      out_q <= res_d;
    end
  end

endmodule

### hdl/text_console_cursor_writer.sv
// top level of the text console cursor writer
//
//   channel   | direction | contents
//   s_axis    | in        | tdata: character[7:0], direction[9:8]; tuser: mode
//   m_axis    | out       | tdata: address, value, row, column; tuser: action; tlast
//   text_color| in        | write enable and attribute byte
//
// one result word per cycle from the back sequencer unless the output stalls or no command
// waits; an input word yields one to six results (tab with overflow is the longest)
// the front register and a four-word command queue let input words keep arriving
// while the back stage works or the output stalls
// reset clears cursor to home, color to 0x0f and empties the queue; no clearing pass
`timescale 1ns / 1ps

module text_console_cursor_writer import tccw_pkg::*; #(
  parameter int unsigned COLUMNS    = COLUMNS_DEF,
  parameter int unsigned ROWS       = ROWS_DEF,
  parameter int unsigned TAB_BLANKS = TAB_BLANKS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // character[7:0], direction[9:8], zeros
  input  logic [0:0]         s_axis_tuser,   // mode[0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,   // cell_address[10:0], cell_value[26:11],
                                             // row[31:27], column[38:32], zero[39]
  output logic [1:0]         m_axis_tuser,   // action[1:0]
  output logic               m_axis_tlast,
  input  logic               text_color_we_i,
  input  logic [COLOR_W-1:0] text_color_i
);

  logic [COLOR_W-1:0] color_q;
  logic               f_valid;
  logic               f_ready;
  cmd_t               f_cmd;
  logic               q_valid;
  logic               q_ready;
  cmd_t               q_cmd;
  result_t            res;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (text_color_we_i) begin
      color_q <= text_color_i;
    end
  end

  tccw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser[0]),
    .character_i (s_axis_tdata[7:0]),
    .direction_i (s_axis_tdata[9:8]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  tccw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_i       (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_cmd)
  );

  tccw_back #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_BLANKS (TAB_BLANKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .color_i     (color_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // output word packing
  assign m_axis_tdata = {1'b0, res.col, res.row, res.value, res.addr};
  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;

  // only the cursor report closes an item
  a_last_is_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (res.action == ACT_REPORT)))
    else $error("tlast does not match cursor report");

  // cursor stays on screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((32'(res.row) < ROWS) && (32'(res.col) < COLUMNS)))
    else $error("cursor left the screen");

  // a clear homes the cursor and targets cell zero
  a_clear_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.action == ACT_CLEAR)) |->
      ((res.addr == '0) && (res.row == '0) && (res.col == '0)))
    else $error("clear result without home cursor");

  // a clear is always followed by the closing report
  a_clear_then_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && (res.action == ACT_CLEAR)) |=>
      (!m_axis_tvalid || (res.action == ACT_REPORT)))
    else $error("clear not followed by report");

endmodule
